@@ hw/rtl/svf_pkg.sv @@
// ----------------------------------------------------------------------------
// svf_pkg
// Shared constants, types and the sequencer program of the state variable
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package svf_pkg;

    // Default widths
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // Coefficient register widths
    localparam int ALPHA0_W = 21;
    localparam int G_W      = 25;
    localparam int RHO_W    = 25;
    localparam int DAMP_W   = 22;
    localparam int COEF_W   = 25;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_G      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP   = 2'd3;

    // Datapath widths: integrators, clamped highpass accumulator, product
    localparam int INT_W    = 32;
    localparam int ACC_LIM_EXP = 40;
    localparam int ACC_W    = ACC_LIM_EXP + 2;
    localparam int PROD_W   = COEF_W + 1 + ACC_W;

    // Control word fields
    typedef logic [1:0] t_csel;
    typedef logic [1:0] t_osel;
    typedef logic [2:0] t_alu;

    localparam t_csel CSEL_ALPHA0 = 2'd0;
    localparam t_csel CSEL_G      = 2'd1;
    localparam t_csel CSEL_RHO    = 2'd2;
    localparam t_csel CSEL_DAMP   = 2'd3;

    localparam t_osel OSEL_Z1  = 2'd0;
    localparam t_osel OSEL_ACC = 2'd1;
    localparam t_osel OSEL_HP  = 2'd2;
    localparam t_osel OSEL_BP  = 2'd3;

    localparam t_alu ALU_NONE   = 3'd0;
    localparam t_alu ALU_LOAD   = 3'd1;
    localparam t_alu ALU_ACC    = 3'd2;
    localparam t_alu ALU_HP     = 3'd3;
    localparam t_alu ALU_BP     = 3'd4;
    localparam t_alu ALU_LP     = 3'd5;
    localparam t_alu ALU_FINISH = 3'd6;

    typedef struct packed {
        logic  wait_in;
        logic  wait_out;
        logic  last;
        logic  mul_en;
        t_csel csel;
        t_osel osel;
        t_alu  alu;
    } t_uop;

    localparam int NSTEP  = 9;
    localparam int STEP_W = $clog2(NSTEP);
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_LAST = t_step'(NSTEP - 1);

    // The program. The multiplier result of one step is consumed by the
    // arithmetic unit in the next step.
    function automatic t_uop prog(input t_step s);
        t_uop u;
        u = '{wait_in: 1'b0, wait_out: 1'b0, last: 1'b0, mul_en: 1'b0,
              csel: CSEL_G, osel: OSEL_Z1, alu: ALU_NONE};
        case (s)
            t_step'(0): begin
                u.wait_in = 1'b1;
                u.mul_en  = 1'b1;
                u.csel    = CSEL_RHO;
                u.osel    = OSEL_Z1;
                u.alu     = ALU_LOAD;
            end
            t_step'(1): begin
                u.alu = ALU_ACC;
            end
            t_step'(2): begin
                u.mul_en = 1'b1;
                u.csel   = CSEL_ALPHA0;
                u.osel   = OSEL_ACC;
            end
            t_step'(3): begin
                u.alu = ALU_HP;
            end
            t_step'(4): begin
                u.mul_en = 1'b1;
                u.csel   = CSEL_G;
                u.osel   = OSEL_HP;
            end
            t_step'(5): begin
                u.alu = ALU_BP;
            end
            t_step'(6): begin
                u.mul_en = 1'b1;
                u.csel   = CSEL_G;
                u.osel   = OSEL_BP;
            end
            t_step'(7): begin
                u.mul_en = 1'b1;
                u.csel   = CSEL_DAMP;
                u.osel   = OSEL_BP;
                u.alu    = ALU_LP;
            end
            t_step'(8): begin
                u.wait_out = 1'b1;
                u.last     = 1'b1;
                u.alu      = ALU_FINISH;
            end
            default: begin
                u.last = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/svf_in_if.sv @@
// ----------------------------------------------------------------------------
// svf_in_if
// Sample channel into the filter: valid, ready and one audio sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface svf_in_if #(
    parameter int W = svf_pkg::SAMPLE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/svf_out_if.sv @@
// ----------------------------------------------------------------------------
// svf_out_if
// Result channel out of the filter: valid, ready and the four responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface svf_out_if #(
    parameter int W = svf_pkg::SAMPLE_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] highpass;
    logic signed [W-1:0] bandpass;
    logic signed [W-1:0] lowpass;
    logic signed [W-1:0] notch;

    modport source (output valid, output highpass, output bandpass,
                    output lowpass, output notch, input ready);
    modport sink   (input valid, input highpass, input bandpass,
                    input lowpass, input notch, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/state_variable_filter.sv @@
// ----------------------------------------------------------------------------
// state_variable_filter
// Two-integrator state variable filter run by a nine-step microprogram over
// one shared coefficient multiplier and one add/saturate unit.
// ----------------------------------------------------------------------------
// Results are registered at the final step of the program, which can stall on the output.
// A new item is taken only at the head of the program, whose length is set by the five
// dependent products that share the single multiplier, each followed by a rounding and
// saturating step. The result register lets the next item start while a result waits.
// Reset (synchronous, active low) clears the sequencer, the result valid flag
// and both integrators, and loads the default coefficients.
`default_nettype none

module state_variable_filter #(
    parameter int SAMPLE_WIDTH   = svf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [svf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [svf_pkg::COEF_W-1:0]     i_cfg_data,
    svf_in_if.sink                              i_smp,
    svf_out_if.source                           o_res
);

    localparam int COEF_W = svf_pkg::COEF_W;
    localparam int ACC_W  = svf_pkg::ACC_W;
    localparam int INT_W  = svf_pkg::INT_W;
    localparam int PROD_W = svf_pkg::PROD_W;
    localparam int EW     = PROD_W + 2;
    // Rounded g-products: 25-bit unsigned times 32-bit signed, shifted down
    localparam int GW     = COEF_W + INT_W + 1 - COEF_FRAC_BITS;

    localparam logic signed [PROD_W-1:0] HALF =
        PROD_W'(1) << (COEF_FRAC_BITS - 1);

    localparam logic signed [EW-1:0] INT_HI = (EW'(1) << (INT_W - 1)) - EW'(1);
    localparam logic signed [EW-1:0] INT_LO = ~INT_HI;
    localparam logic signed [EW-1:0] OUT_HI = (EW'(1) << (SAMPLE_WIDTH - 1)) - EW'(1);
    localparam logic signed [EW-1:0] OUT_LO = ~OUT_HI;
    localparam logic signed [EW-1:0] ACC_HI = EW'(1) << svf_pkg::ACC_LIM_EXP;
    localparam logic signed [EW-1:0] ACC_LO = -ACC_HI;

    localparam logic [svf_pkg::ALPHA0_W-1:0] RST_ALPHA0 =
        svf_pkg::ALPHA0_W'(64'd1 << COEF_FRAC_BITS);
    localparam logic [svf_pkg::G_W-1:0] RST_G =
        svf_pkg::G_W'(64'd1 << COEF_FRAC_BITS);
    localparam logic [svf_pkg::RHO_W-1:0] RST_RHO =
        svf_pkg::RHO_W'(64'd1 << COEF_FRAC_BITS);
    localparam logic [svf_pkg::DAMP_W-1:0] RST_DAMP =
        svf_pkg::DAMP_W'(64'd2 << COEF_FRAC_BITS);

    function automatic logic signed [EW-1:0] clamp_w(
        input logic signed [EW-1:0] v,
        input logic signed [EW-1:0] lo,
        input logic signed [EW-1:0] hi
    );
        logic signed [EW-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Configuration
    logic [svf_pkg::ALPHA0_W-1:0] r_alpha0;
    logic [svf_pkg::G_W-1:0]      r_g;
    logic [svf_pkg::RHO_W-1:0]    r_rho;
    logic [svf_pkg::DAMP_W-1:0]   r_damp;

    // Sequencer
    svf_pkg::t_step r_step;
    svf_pkg::t_step n_step;
    svf_pkg::t_uop  uop;
    logic           hold;
    logic           exec;
    logic           out_free;

    // Datapath registers
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [PROD_W-1:0]       n_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [INT_W-1:0]        r_hp;
    logic signed [INT_W-1:0]        r_bp;
    logic signed [INT_W-1:0]        r_lp;
    logic signed [GW-1:0]           r_ghp;
    logic signed [GW-1:0]           r_gbp;
    logic signed [INT_W-1:0]        r_z1;
    logic signed [INT_W-1:0]        r_z2;

    logic                           r_ovalid;
    logic signed [SAMPLE_WIDTH-1:0] r_o_hp;
    logic signed [SAMPLE_WIDTH-1:0] r_o_bp;
    logic signed [SAMPLE_WIDTH-1:0] r_o_lp;
    logic signed [SAMPLE_WIDTH-1:0] r_o_notch;

    // Multiplier operands
    logic signed [COEF_W:0]   mul_a;
    logic signed [ACC_W-1:0]  mul_b;

    // Arithmetic unit
    logic signed [PROD_W-1:0] rnd_half;
    logic signed [PROD_W-1:0] rnd;
    logic signed [EW-1:0]     rnd_e;
    logic signed [EW-1:0]     x_e;
    logic signed [EW-1:0]     z1_e;
    logic signed [EW-1:0]     z2_e;
    logic signed [EW-1:0]     acc_v;
    logic signed [EW-1:0]     hp_v;
    logic signed [EW-1:0]     bp_v;
    logic signed [EW-1:0]     lp_v;
    logic signed [EW-1:0]     notch_v;
    logic signed [EW-1:0]     z1_v;
    logic signed [EW-1:0]     z2_v;

    assign uop      = svf_pkg::prog(r_step);
    assign out_free = !r_ovalid || o_res.ready;
    assign hold     = (uop.wait_in && !i_smp.valid) || (uop.wait_out && !out_free);
    assign exec     = !hold;
    assign n_step   = uop.last ? '0 : r_step + svf_pkg::t_step'(1);

    assign i_smp.ready = uop.wait_in;

    always_comb begin
        case (uop.csel)
            svf_pkg::CSEL_ALPHA0: mul_a = {1'b0, COEF_W'(r_alpha0)};
            svf_pkg::CSEL_G:      mul_a = {1'b0, COEF_W'(r_g)};
            svf_pkg::CSEL_RHO:    mul_a = {1'b0, COEF_W'(r_rho)};
            svf_pkg::CSEL_DAMP:   mul_a = {1'b0, COEF_W'(r_damp)};
            default:              mul_a = '0;
        endcase
        case (uop.osel)
            svf_pkg::OSEL_Z1:  mul_b = ACC_W'(r_z1);
            svf_pkg::OSEL_ACC: mul_b = r_acc;
            svf_pkg::OSEL_HP:  mul_b = ACC_W'(r_hp);
            svf_pkg::OSEL_BP:  mul_b = ACC_W'(r_bp);
            default:           mul_b = '0;
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Round half up: add half an LSB, then floor by the arithmetic shift.
    assign rnd_half = r_prod + HALF;
    assign rnd      = rnd_half >>> COEF_FRAC_BITS;
    assign rnd_e    = EW'(rnd);
    assign x_e      = EW'(r_x);
    assign z1_e     = EW'(r_z1);
    assign z2_e     = EW'(r_z2);

    assign acc_v   = clamp_w(x_e - rnd_e - z2_e, ACC_LO, ACC_HI);
    assign hp_v    = clamp_w(rnd_e, INT_LO, INT_HI);
    assign bp_v    = clamp_w(rnd_e + z1_e, INT_LO, INT_HI);
    assign lp_v    = clamp_w(rnd_e + z2_e, INT_LO, INT_HI);
    assign notch_v = clamp_w(x_e - rnd_e, OUT_LO, OUT_HI);
    assign z1_v    = clamp_w(EW'(r_ghp) + EW'(r_bp), INT_LO, INT_HI);
    assign z2_v    = clamp_w(EW'(r_gbp) + EW'(r_lp), INT_LO, INT_HI);

    // Control state, configuration and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_z1     <= '0;
            r_z2     <= '0;
            r_alpha0 <= RST_ALPHA0;
            r_g      <= RST_G;
            r_rho    <= RST_RHO;
            r_damp   <= RST_DAMP;
        end else begin
            if (exec) begin
                r_step <= n_step;
            end
            if (exec && uop.alu == svf_pkg::ALU_FINISH) begin
                r_ovalid <= 1'b1;
                r_z1     <= INT_W'(z1_v);
                r_z2     <= INT_W'(z2_v);
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    svf_pkg::CFG_ALPHA0: r_alpha0 <= i_cfg_data[svf_pkg::ALPHA0_W-1:0];
                    svf_pkg::CFG_G:      r_g      <= i_cfg_data[svf_pkg::G_W-1:0];
                    svf_pkg::CFG_RHO:    r_rho    <= i_cfg_data[svf_pkg::RHO_W-1:0];
                    svf_pkg::CFG_DAMP:   r_damp   <= i_cfg_data[svf_pkg::DAMP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        if (exec && uop.mul_en) begin
            r_prod <= n_prod;
        end
        if (exec) begin
            case (uop.alu)
                svf_pkg::ALU_LOAD: begin
                    r_x <= i_smp.sample;
                end
                svf_pkg::ALU_ACC: begin
                    r_acc <= ACC_W'(acc_v);
                end
                svf_pkg::ALU_HP: begin
                    r_hp <= INT_W'(hp_v);
                end
                svf_pkg::ALU_BP: begin
                    r_ghp <= rnd[GW-1:0];
                    r_bp  <= INT_W'(bp_v);
                end
                svf_pkg::ALU_LP: begin
                    r_gbp <= rnd[GW-1:0];
                    r_lp  <= INT_W'(lp_v);
                end
                svf_pkg::ALU_FINISH: begin
                    r_o_hp    <= SAMPLE_WIDTH'(clamp_w(EW'(r_hp), OUT_LO, OUT_HI));
                    r_o_bp    <= SAMPLE_WIDTH'(clamp_w(EW'(r_bp), OUT_LO, OUT_HI));
                    r_o_lp    <= SAMPLE_WIDTH'(clamp_w(EW'(r_lp), OUT_LO, OUT_HI));
                    r_o_notch <= SAMPLE_WIDTH'(notch_v);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.highpass = r_o_hp;
    assign o_res.bandpass = r_o_bp;
    assign o_res.lowpass  = r_o_lp;
    assign o_res.notch    = r_o_notch;

    // Samples are only taken at the head of the program.
    a_take_at_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |-> (r_step == '0))
        else $error("sample taken away from the head of the program");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= svf_pkg::STEP_LAST)
        else $error("step counter beyond the program");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == svf_pkg::STEP_LAST && exec) |=> r_ovalid)
        else $error("finished item did not reach the result register");

    a_int_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_step == svf_pkg::STEP_LAST && exec) |=> ($stable(r_z1) && $stable(r_z2)))
        else $error("integrators changed outside the final step");

    a_idle_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == '0 && !i_smp.valid) |=> (r_step == '0))
        else $error("program left its head without a sample");

endmodule

`default_nettype wire
